@@ src/cht_pkg.sv @@
package cht_pkg;

	// Command codes of an input word.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// Multipliers of the murmur3 32-bit finalizer.
	localparam logic [31:0] FMIX_C1 = 32'h85ebca6b;
	localparam logic [31:0] FMIX_C2 = 32'hc2b2ae35;

	localparam logic [31:0] COUNT_MAX = 32'hffffffff;

	// Controller to datapath commands.
	typedef struct packed {
		logic clr_step;
		logic load;
		logic hash_a;
		logic hash_b;
		logic row_load;
		logic mem_rd;
		logic finish;
	} cht_ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} cht_sts_t;

endpackage

@@ src/counting_hash_table.sv @@
// Counting hash table. Each input word carries a command: insert a 32-bit key,
// look a key up, or read one slot out for export. The key is hashed with the
// murmur3 32-bit finalizer and the low hash bits pick one of BUCKETS buckets
// of WAYS slots, so BUCKETS must be a power of two; slot number is
// bucket * WAYS + way. An insert of a present key bumps
// its count, which saturates at all ones; a new key takes the lowest free way
// with count one, or is dropped with the dropped flag set when the bucket is
// full. Every input word yields exactly one result word, which also reports
// the number of distinct keys stored. After reset the block runs a clearing
// pass, one bucket row per cycle, and takes no input word until it is done.
// The block then works on one word at a time: an accepted word passes through
// the two registered hash multiplies, the registered bucket selection, and the
// registered read and write-back of the bucket row memory before the next word
// can be accepted. While an earlier result is stalled, the write-back waits
// until the output register is free. A finished result waits in the output
// register while the next word is already accepted.
module counting_hash_table #(
	parameter int BUCKETS = 256,
	parameter int WAYS    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] key,
	input  logic [9:0]  slot_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] entry_count,
	output logic [31:0] entry_key,
	output logic        dropped,
	output logic [10:0] stored_total
);
	import cht_pkg::*;

	cht_ctl_t ctl;
	cht_sts_t sts;

	// The controller sequences each word through hash, bucket selection, read
	// and write-back; the datapath owns the data registers and the memory.
	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	cht_dp #(
		.BUCKETS (BUCKETS),
		.WAYS    (WAYS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cmd          (cmd),
		.key          (key),
		.slot_index   (slot_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.entry_count  (entry_count),
		.entry_key    (entry_key),
		.dropped      (dropped),
		.stored_total (stored_total)
	);

`ifndef SYNTH
	// Only one word is in flight, so an accepted word closes the input.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a word was in flight");

	// A dropped key was never present and carries no count.
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> !found && entry_count == 32'd0)
		else $error("dropped result reports a present key or a count");

	// Any stored entry has been counted at least once.
	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> entry_count != 32'd0)
		else $error("present entry reports a zero count");
`endif

endmodule

@@ src/cht_ctrl.sv @@
module cht_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  cht_pkg::cht_sts_t sts,
	output cht_pkg::cht_ctl_t ctl
);
	import cht_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH_A,
		ST_HASH_B,
		ST_ROW,
		ST_READ,
		ST_RESP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_HASH_A;
				end
				ST_HASH_A: state_q <= ST_HASH_B;
				ST_HASH_B: state_q <= ST_ROW;
				ST_ROW: state_q <= ST_READ;
				ST_READ: state_q <= ST_RESP;
				ST_RESP: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign ctl.clr_step = (state_q == ST_CLEAR);
	assign ctl.load     = (state_q == ST_IDLE) && in_valid;
	assign ctl.hash_a   = (state_q == ST_HASH_A);
	assign ctl.hash_b   = (state_q == ST_HASH_B);
	assign ctl.row_load = (state_q == ST_ROW);
	assign ctl.mem_rd   = (state_q == ST_READ);
	assign ctl.finish   = (state_q == ST_RESP) && sts.out_free;

endmodule

@@ src/cht_dp.sv @@
module cht_dp #(
	parameter int BUCKETS = 256,
	parameter int WAYS    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cht_pkg::cht_ctl_t ctl,
	output cht_pkg::cht_sts_t sts,
	input  logic [1:0]        cmd,
	input  logic [31:0]       key,
	input  logic [9:0]        slot_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [31:0]       entry_count,
	output logic [31:0]       entry_key,
	output logic              dropped,
	output logic [10:0]       stored_total
);
	import cht_pkg::*;

	localparam int AW     = $clog2(BUCKETS);
	localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int KOFF   = WAYS;
	localparam int COFF   = WAYS + 32 * WAYS;
	localparam int ROWW   = WAYS * 65;
	localparam logic [20:0] RECIP = 21'((2 ** 20 + WAYS - 1) / WAYS);
	localparam logic [31:0] NSLOTS = 32'(BUCKETS * WAYS);

	// Item registers.
	logic [1:0]  cmd_q;
	logic [31:0] key_q;
	logic [9:0]  sidx_q;

	// Hash and row selection.
	logic [31:0] mul1_q, mul2_q, hash;
	logic [AW-1:0] rem_q;
	logic [9:0]  rq_q;
	logic [10:0] rb_q;
	logic [WW-1:0] rw_q;
	logic [AW-1:0] row_q, clr_q;

	// Store.
	logic [ROWW-1:0] mem_q [BUCKETS];
	logic [ROWW-1:0] rd_q, wr_row;
	logic            mem_we;
	logic [AW-1:0]   mem_wa;

	logic [10:0] tot_q;

	// Hash pipeline: fold, multiply, fold, multiply, fold.
	logic [31:0] fold0, fold1;
	assign fold0 = key_q ^ (key_q >> 16);
	assign fold1 = mul1_q ^ (mul1_q >> 13);
	assign hash  = mul2_q ^ (mul2_q >> 16);

	// Read-out slot split into bucket and way by reciprocal multiply.
	logic [30:0] div_prod;
	logic [14:0] div_rem;
	logic        in_range;
	logic [AW+10:0] ro_wide;
	assign div_prod = 31'(sidx_q) * 31'(RECIP);
	assign div_rem  = 15'(sidx_q) - 15'(rq_q) * 15'(WAYS);
	assign in_range = {22'd0, sidx_q} < NSLOTS;
	assign ro_wide  = {{AW{1'b0}}, rb_q};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			key_q  <= key;
			sidx_q <= slot_index;
		end
		if (ctl.hash_a) begin
			mul1_q <= fold0 * FMIX_C1;
			rq_q   <= div_prod[29:20];
		end
		if (ctl.hash_b) begin
			mul2_q <= fold1 * FMIX_C2;
			if (div_rem >= 15'(WAYS)) begin
				rb_q <= 11'(rq_q) + 11'd1;
				rw_q <= WW'(div_rem - 15'(WAYS));
			end else begin
				rb_q <= 11'(rq_q);
				rw_q <= WW'(div_rem);
			end
		end
		// BUCKETS is a power of two, so the bucket is the low hash bits.
		if (ctl.row_load) begin
			rem_q <= hash[AW-1:0];
		end
		if (ctl.mem_rd) begin
			if (cmd_q == CMD_READ) begin
				row_q <= in_range ? ro_wide[AW-1:0] : '0;
			end else begin
				row_q <= rem_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else begin
			if (ctl.clr_step) clr_q <= clr_q + AW'(1);
		end
	end

	assign sts.clr_last = (clr_q == AW'(BUCKETS - 1));

	// Memory: one row per bucket, all ways side by side.
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= wr_row;
		if (ctl.mem_rd) begin
			if (cmd_q == CMD_READ) begin
				rd_q <= mem_q[in_range ? ro_wide[AW-1:0] : '0];
			end else begin
				rd_q <= mem_q[rem_q];
			end
		end
	end

	// Bucket search and update.
	logic [WAYS-1:0]       rv, wv;
	logic [WAYS-1:0][31:0] rk, rc, wk, wc;
	logic                  hit, free;
	logic [WW-1:0]         hw, fw;
	logic [31:0]           inc, res_cnt;
	logic                  is_ins, is_key;

	assign rv = rd_q[WAYS-1:0];
	assign rk = rd_q[KOFF +: 32 * WAYS];
	assign rc = rd_q[COFF +: 32 * WAYS];
	assign is_ins = (cmd_q == CMD_INSERT);
	assign is_key = (cmd_q == CMD_INSERT) || (cmd_q == CMD_LOOKUP);

	always_comb begin
		hit = 1'b0;
		free = 1'b0;
		hw = '0;
		fw = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rv[w] && rk[w] == key_q) begin
				hit = 1'b1;
				hw = WW'(w);
			end
			if (!rv[w]) begin
				free = 1'b1;
				fw = WW'(w);
			end
		end
	end

	assign inc = (rc[hw] == COUNT_MAX) ? rc[hw] : rc[hw] + 32'd1;

	always_comb begin
		wv = rv;
		wk = rk;
		wc = rc;
		if (hit) begin
			wc[hw] = inc;
		end else begin
			wv[fw] = 1'b1;
			wk[fw] = key_q;
			wc[fw] = 32'd1;
		end
		if (hit) res_cnt = is_ins ? inc : rc[hw];
		else res_cnt = (is_ins && free) ? 32'd1 : 32'd0;
	end

	always_comb begin
		if (ctl.clr_step) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			wr_row = '0;
		end else begin
			mem_we = ctl.finish && is_ins && (hit || free);
			mem_wa = row_q;
			wr_row = {wc, wk, wv};
		end
	end

	// Result register.
	logic ro_ok;
	assign ro_ok = in_range && rv[rw_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			tot_q     <= '0;
		end else begin
			if (ctl.finish) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (ctl.finish && is_ins && !hit && free) tot_q <= tot_q + 11'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			if (is_key) begin
				found       <= hit;
				entry_count <= res_cnt;
				entry_key   <= key_q;
				dropped     <= is_ins && !hit && !free;
			end else if (cmd_q == CMD_READ) begin
				found       <= ro_ok;
				entry_count <= ro_ok ? rc[rw_q] : 32'd0;
				entry_key   <= ro_ok ? rk[rw_q] : 32'd0;
				dropped     <= 1'b0;
			end else begin
				found       <= 1'b0;
				entry_count <= 32'd0;
				entry_key   <= 32'd0;
				dropped     <= 1'b0;
			end
			stored_total <= tot_q + ((is_ins && !hit && free) ? 11'd1 : 11'd0);
		end
	end

	assign sts.out_free = !out_valid || !out_stall;

endmodule
